@@ sv/gtpw_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the greedy terrain path walk unit.
// No dependencies; used by the controller, datapath and top level.
package gtpw_pkg;

  localparam int COORD_W    = 8;
  localparam int COLOR_W    = 8;
  localparam int DIST_W     = 24;
  localparam int ELEV_IN_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Command codes carried on in_cmd.
  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE  = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_STEP,
    S_EMIT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;    // input beat taken this cycle
    logic rd_b;      // read diagonal neighbors, latch here/right data
    logic step;      // pick the move and update the walker
    logic load_out;  // capture the result beat
  } ctrl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic at_end;    // walker stands on or past the last column in use
  } status_t;

endpackage

@@ sv/gtpw_ram.sv @@
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module gtpw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a_r,
  output logic [WIDTH-1:0] rd_data_b_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a_r <= mem[rd_addr_a];
    rd_data_b_r <= mem[rd_addr_b];
  end

endmodule

@@ sv/gtpw_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the path walk unit: input/output handshake and step order.
// Depends on gtpw_pkg.
module gtpw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_cmd,
  output logic             out_valid,
  input  logic             out_ready,
  input  gtpw_pkg::status_t status,
  output gtpw_pkg::ctrl_t   ctrl
);

  gtpw_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gtpw_pkg::S_IDLE: begin
        if (in_valid) begin
          if (gtpw_pkg::cmd_t'(in_cmd) == gtpw_pkg::CMD_ADVANCE && !status.at_end) begin
            state_nxt = gtpw_pkg::S_RD_A;
          end else begin
            state_nxt = gtpw_pkg::S_EMIT;
          end
        end
      end
      gtpw_pkg::S_RD_A: state_nxt = gtpw_pkg::S_RD_B;
      gtpw_pkg::S_RD_B: state_nxt = gtpw_pkg::S_STEP;
      gtpw_pkg::S_STEP: state_nxt = gtpw_pkg::S_EMIT;
      gtpw_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = gtpw_pkg::S_IDLE;
        end
      end
      default: state_nxt = gtpw_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == gtpw_pkg::S_IDLE);
    ctrl.accept   = (state_r == gtpw_pkg::S_IDLE) && in_valid;
    ctrl.rd_b     = (state_r == gtpw_pkg::S_RD_B);
    ctrl.step     = (state_r == gtpw_pkg::S_STEP);
    ctrl.load_out = (state_r == gtpw_pkg::S_EMIT) && out_free;
    if (ctrl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gtpw_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_step_after_reads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gtpw_pkg::S_STEP |-> $past(state_r) == gtpw_pkg::S_RD_B)
    else $error("step state entered without neighbor reads");

  a_advance_starts_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && gtpw_pkg::cmd_t'(in_cmd) == gtpw_pkg::CMD_ADVANCE
     && !status.at_end) |=> state_r == gtpw_pkg::S_RD_A)
    else $error("advance beat did not start the read sequence");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && state_r == gtpw_pkg::S_IDLE)
    else $error("reset did not clear the sequencer");
`endif

endmodule

@@ sv/gtpw_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the path walk unit: configuration, walker state, elevation RAM,
// move selection and the result register. Depends on gtpw_pkg and gtpw_ram.
module gtpw_dp #(
  parameter int MAX_ROWS       = 256,
  parameter int MAX_COLS       = 256,
  parameter int ELEVATION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gtpw_pkg::ctrl_t                     ctrl,
  output gtpw_pkg::status_t                   status,
  input  logic                                cfg_valid,
  input  logic [gtpw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gtpw_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [1:0]                          in_cmd,
  input  logic [gtpw_pkg::COORD_W-1:0]        in_cell_row,
  input  logic [gtpw_pkg::COORD_W-1:0]        in_cell_column,
  input  logic [gtpw_pkg::ELEV_IN_W-1:0]      in_elevation,
  output logic [gtpw_pkg::COORD_W-1:0]        out_path_column,
  output logic [gtpw_pkg::COORD_W-1:0]        out_path_row,
  output logic [gtpw_pkg::COLOR_W-1:0]        out_pixel_red,
  output logic [gtpw_pkg::COLOR_W-1:0]        out_pixel_green,
  output logic [gtpw_pkg::COLOR_W-1:0]        out_pixel_blue,
  output logic [gtpw_pkg::DIST_W-1:0]         out_total_distance,
  output logic                                out_walk_done
);

  localparam int EW      = ELEVATION_BITS;
  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = gtpw_pkg::CFG_DATA_W;
  localparam int RW      = gtpw_pkg::COORD_W;
  localparam int DW      = gtpw_pkg::DIST_W;
  localparam int SUM_W   = ((EW > DW) ? EW : DW) + 1;
  localparam int ROW_CAP = (MAX_ROWS < 256) ? MAX_ROWS : 256;
  localparam int COL_CAP = (MAX_COLS < 256) ? MAX_COLS : 256;
  localparam logic [CW-1:0] ROW_CAP_V = CW'(ROW_CAP);
  localparam logic [CW-1:0] COL_CAP_V = CW'(COL_CAP);
  localparam logic [CW-1:0] GRID_MIN  = CW'(2);

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                              input logic [RW-1:0] col);
    cell_addr = AW'(row) * AW'(MAX_COLS) + AW'(col);
  endfunction

  function automatic logic [EW-1:0] abs_diff(input logic [EW-1:0] a,
                                             input logic [EW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // Configuration registers
  logic [CW-1:0] rows_r, cols_r;
  logic [RW-1:0] start_r;
  logic [RW-1:0] red_r, green_r, blue_r;

  // Walker state
  logic [RW-1:0] walk_row_r, walk_row_nxt;
  logic [RW-1:0] walk_col_r, walk_col_nxt;
  logic [DW-1:0] dist_r, dist_nxt;
  logic [EW-1:0] here_r, e_diff_r;

  logic [CW-1:0] rows_eff, cols_eff, rows_last9, cols_last9;
  logic [RW-1:0] row_last, r_eff, row_up, row_dn, col_next, restart_row;
  logic          is_top, is_bot;

  logic [AW-1:0] rd_addr_a, rd_addr_b;
  logic [EW-1:0] rd_data_a_r, rd_data_b_r;
  logic          wr_en;

  logic [EW-1:0]    ne_diff, se_diff, step_val;
  logic [RW-1:0]    row_sel;
  logic [SUM_W-1:0] dist_sum;
  gtpw_pkg::cmd_t   cmd;

  assign cmd = gtpw_pkg::cmd_t'(in_cmd);

  // Clamp grid size to the legal range.
  always_comb begin
    priority if (rows_r < GRID_MIN) rows_eff = GRID_MIN;
    else if (rows_r > ROW_CAP_V) rows_eff = ROW_CAP_V;
    else rows_eff = rows_r;
    priority if (cols_r < GRID_MIN) cols_eff = GRID_MIN;
    else if (cols_r > COL_CAP_V) cols_eff = COL_CAP_V;
    else cols_eff = cols_r;
  end

  assign rows_last9  = rows_eff - CW'(1);
  assign cols_last9  = cols_eff - CW'(1);
  assign row_last    = rows_last9[RW-1:0];
  assign r_eff       = (CW'(walk_row_r) > rows_last9) ? row_last : walk_row_r;
  assign row_up      = r_eff - RW'(1);
  assign row_dn      = r_eff + RW'(1);
  assign col_next    = walk_col_r + RW'(1);
  assign is_top      = (r_eff == '0);
  assign is_bot      = (r_eff == row_last);
  assign restart_row = (CW'(start_r) < rows_eff) ? start_r : row_last;
  assign status.at_end = (CW'(walk_col_r) >= cols_last9);

  // Elevation store
  assign wr_en = ctrl.accept && cmd == gtpw_pkg::CMD_WRITE
                 && (32'(in_cell_row) < 32'(MAX_ROWS))
                 && (32'(in_cell_column) < 32'(MAX_COLS));

  always_comb begin
    if (ctrl.rd_b) begin
      rd_addr_a = cell_addr(is_top ? r_eff : row_up, col_next);
      rd_addr_b = cell_addr(is_bot ? r_eff : row_dn, col_next);
    end else begin
      rd_addr_a = cell_addr(r_eff, walk_col_r);
      rd_addr_b = cell_addr(r_eff, col_next);
    end
  end

  gtpw_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_elev_ram (
    .clk         (clk),
    .wr_en       (wr_en),
    .wr_addr     (cell_addr(in_cell_row, in_cell_column)),
    .wr_data     (EW'(in_elevation)),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .rd_data_a_r (rd_data_a_r),
    .rd_data_b_r (rd_data_b_r)
  );

  // Move selection
  assign ne_diff = abs_diff(here_r, rd_data_a_r);
  assign se_diff = abs_diff(here_r, rd_data_b_r);

  always_comb begin
    step_val = e_diff_r;
    row_sel  = r_eff;
    if (is_top) begin
      if (se_diff < e_diff_r) begin
        step_val = se_diff;
        row_sel  = row_dn;
      end
    end else if (is_bot) begin
      if (ne_diff < e_diff_r) begin
        step_val = ne_diff;
        row_sel  = row_up;
      end
    end else begin
      priority if (ne_diff < e_diff_r && ne_diff < se_diff) begin
        step_val = ne_diff;
        row_sel  = row_up;
      end else if (se_diff <= ne_diff && se_diff < e_diff_r) begin
        step_val = se_diff;
        row_sel  = row_dn;
      end else begin
        step_val = e_diff_r;
        row_sel  = r_eff;
      end
    end
  end

  assign dist_sum = SUM_W'(dist_r) + SUM_W'(step_val);

  always_comb begin
    walk_row_nxt = walk_row_r;
    walk_col_nxt = walk_col_r;
    dist_nxt     = dist_r;
    if (ctrl.accept && cmd == gtpw_pkg::CMD_RESTART) begin
      walk_row_nxt = restart_row;
      walk_col_nxt = '0;
      dist_nxt     = '0;
    end else if (ctrl.step) begin
      walk_row_nxt = row_sel;
      walk_col_nxt = col_next;
      dist_nxt     = (dist_sum > SUM_W'(gtpw_pkg::DIST_MAX)) ? gtpw_pkg::DIST_MAX
                                                             : dist_sum[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r     <= CW'(256);
      cols_r     <= CW'(256);
      start_r    <= '0;
      red_r      <= '0;
      green_r    <= '0;
      blue_r     <= '0;
      walk_row_r <= '0;
      walk_col_r <= '0;
      dist_r     <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          gtpw_pkg::CFG_ROWS:  rows_r  <= cfg_data;
          gtpw_pkg::CFG_COLS:  cols_r  <= cfg_data;
          gtpw_pkg::CFG_START: start_r <= cfg_data[RW-1:0];
          gtpw_pkg::CFG_RED:   red_r   <= cfg_data[RW-1:0];
          gtpw_pkg::CFG_GREEN: green_r <= cfg_data[RW-1:0];
          gtpw_pkg::CFG_BLUE:  blue_r  <= cfg_data[RW-1:0];
          default: ;
        endcase
      end
      walk_row_r <= walk_row_nxt;
      walk_col_r <= walk_col_nxt;
      dist_r     <= dist_nxt;
    end
  end

  // Neighbor data and result register carry no reset.
  always_ff @(posedge clk) begin
    if (ctrl.rd_b) begin
      here_r   <= rd_data_a_r;
      e_diff_r <= abs_diff(rd_data_a_r, rd_data_b_r);
    end
    if (ctrl.load_out) begin
      out_path_column    <= walk_col_r;
      out_path_row       <= walk_row_r;
      out_pixel_red      <= red_r;
      out_pixel_green    <= green_r;
      out_pixel_blue     <= blue_r;
      out_total_distance <= dist_r;
      out_walk_done      <= status.at_end;
    end
  end

`ifndef SYNTHESIS
  a_dist_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.accept && cmd == gtpw_pkg::CMD_RESTART) |=> dist_r >= $past(dist_r))
    else $error("distance decreased without a restart");

  a_step_one_column: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.step |=> walk_col_r == $past(walk_col_r) + RW'(1))
    else $error("step did not advance exactly one column");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.accept && cmd == gtpw_pkg::CMD_RESTART) |=> walk_col_r == '0 && dist_r == '0)
    else $error("restart did not clear column and distance");
`endif

endmodule

@@ sv/greedy_terrain_path_walk_unit.sv @@
`timescale 1ns / 1ps
// Top level of the greedy terrain path walk unit.
// Depends on gtpw_pkg, gtpw_ctrl, gtpw_dp (which holds gtpw_ram).

// Every input beat returns exactly one result beat describing the current
// path pixel. A write (cmd 0), restart (cmd 1), unused code (cmd 3) or an
// advance on a finished walk goes from accept straight to loading the result;
// a real advance (cmd 2) first reads the current cell and its three
// right-hand neighbors through the two read ports of the elevation RAM (RD_A,
// RD_B), then compares the changes and updates row, column and distance (STEP),
// then loads the result register. One item is worked on at a time; the next beat
// is taken as soon as the result sits in the output register, even if the
// consumer has not yet taken it. The elevation store is MAX_ROWS x MAX_COLS
// entries of ELEVATION_BITS, has no clearing pass and must be written before
// a walk reads it. Configuration beats are always taken (cfg_ready is high)
// and must only be sent while the unit is idle.
module greedy_terrain_path_walk_unit #(
  parameter int MAX_ROWS       = 256,
  parameter int MAX_COLS       = 256,
  parameter int ELEVATION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gtpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gtpw_pkg::CFG_DATA_W-1:0] cfg_data,
  // command channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_cmd,
  input  logic [gtpw_pkg::COORD_W-1:0]    in_cell_row,
  input  logic [gtpw_pkg::COORD_W-1:0]    in_cell_column,
  input  logic [gtpw_pkg::ELEV_IN_W-1:0]  in_elevation,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gtpw_pkg::COORD_W-1:0]    out_path_column,
  output logic [gtpw_pkg::COORD_W-1:0]    out_path_row,
  output logic [gtpw_pkg::COLOR_W-1:0]    out_pixel_red,
  output logic [gtpw_pkg::COLOR_W-1:0]    out_pixel_green,
  output logic [gtpw_pkg::COLOR_W-1:0]    out_pixel_blue,
  output logic [gtpw_pkg::DIST_W-1:0]     out_total_distance,
  output logic                            out_walk_done
);

  gtpw_pkg::ctrl_t   ctrl;
  gtpw_pkg::status_t status;

  // Registers are plain flops: accept a configuration beat every cycle.
  assign cfg_ready = 1'b1;

  // Sequencer: owns the handshakes and the read/compare/update order.
  gtpw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  // Datapath: config registers, walker, elevation RAM and result register.
  gtpw_dp #(
    .MAX_ROWS       (MAX_ROWS),
    .MAX_COLS       (MAX_COLS),
    .ELEVATION_BITS (ELEVATION_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .status             (status),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_cmd             (in_cmd),
    .in_cell_row        (in_cell_row),
    .in_cell_column     (in_cell_column),
    .in_elevation       (in_elevation),
    .out_path_column    (out_path_column),
    .out_path_row       (out_path_row),
    .out_pixel_red      (out_pixel_red),
    .out_pixel_green    (out_pixel_green),
    .out_pixel_blue     (out_pixel_blue),
    .out_total_distance (out_total_distance),
    .out_walk_done      (out_walk_done)
  );

endmodule
